// ----- rtl/cs2rgba_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cs2rgba_pkg
// Shared widths, stage counts, register indexes, mode codes and color
// conversion coefficients for the component sample to RGBA converter.
// ----------------------------------------------------------------------------
package cs2rgba_pkg;

    localparam int SAMPLE_W     = 32;
    localparam int BYTE_W       = 8;
    localparam int LANE_COUNT   = 4;
    localparam int PREC_W       = 5;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 20;

    // lane: clamp stage, numerator stage, one stage per quotient bit
    localparam int DIV_STEPS    = BYTE_W;
    localparam int DIV_BASE     = 2;
    localparam int LANE_STAGES  = DIV_BASE + DIV_STEPS;
    localparam int MERGE_STAGES = 2;
    localparam int PIPE_STAGES  = LANE_STAGES + MERGE_STAGES;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_MODE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COLOR_MODE   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PRECISIONS   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SIGNED_FLAGS = 2'd3;

    // channel modes; the unused code behaves as four components
    localparam logic [1:0] CH_GRAY  = 2'd0;
    localparam logic [1:0] CH_THREE = 2'd1;
    localparam logic [1:0] CH_FOUR  = 2'd2;

    localparam logic COLOR_RGB = 1'b0;
    localparam logic COLOR_YCC = 1'b1;

    // reset values
    localparam logic [1:0]                   RST_CHANNEL_MODE = CH_THREE;
    localparam logic                         RST_COLOR_MODE   = COLOR_RGB;
    localparam logic [LANE_COUNT*PREC_W-1:0] RST_PRECISIONS   = 20'd270600;
    localparam logic [LANE_COUNT-1:0]        RST_SIGNED_FLAGS = 4'd0;

    // Q1.16 coefficients
    localparam int COEF_W = 17;
    localparam logic [COEF_W-1:0] COEF_KR  = 17'd91881;
    localparam logic [COEF_W-1:0] COEF_KGB = 17'd22553;
    localparam logic [COEF_W-1:0] COEF_KGR = 17'd46802;
    localparam logic [COEF_W-1:0] COEF_KB  = 17'd116130;

    localparam logic [BYTE_W-1:0] CHROMA_BIAS = 8'd128;
    localparam logic [BYTE_W-1:0] BYTE_MAX    = 8'hFF;

    typedef logic [BYTE_W-1:0] byte_t;

    typedef struct packed {
        logic [1:0] channel_mode;
        logic       color_mode;
    } pix_mode_t;

endpackage

// ----- rtl/cs2rgba_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cs2rgba_lane
// One component lane: clamps a sample to its precision's range and rescales
// it to a byte with a pipelined restoring divider, one quotient bit a stage.
// ----------------------------------------------------------------------------
module cs2rgba_lane #(
    parameter int MAX_PRECISION = 31
) (
    input  logic                                clk,
    input  logic [cs2rgba_pkg::LANE_STAGES-1:0] en,
    input  logic [cs2rgba_pkg::SAMPLE_W-1:0]    sample,
    input  logic [cs2rgba_pkg::PREC_W-1:0]      precision,
    input  logic                                sign_mode,
    output cs2rgba_pkg::byte_t                  value
);

    localparam int PW     = cs2rgba_pkg::PREC_W;
    localparam int BW     = cs2rgba_pkg::BYTE_W;
    localparam int STEPS  = cs2rgba_pkg::DIV_STEPS;
    localparam int BASE   = cs2rgba_pkg::DIV_BASE;
    localparam int CMP_W  = cs2rgba_pkg::SAMPLE_W + 1;
    localparam int OFF_W  = MAX_PRECISION;
    localparam int NUM_W  = OFF_W + BW;
    localparam logic [PW-1:0] PREC_MAX = MAX_PRECISION[PW-1:0];

    logic [PW-1:0]           prec_eff;
    logic [CMP_W-1:0]        pow_p;
    logic [CMP_W-1:0]        pow_h;
    logic [CMP_W-1:0]        span_full;
    logic [CMP_W-1:0]        half_full;
    logic signed [CMP_W-1:0] hi;
    logic signed [CMP_W-1:0] lo;
    logic signed [CMP_W-1:0] s_ext;
    logic signed [CMP_W-1:0] s_cl;
    logic signed [CMP_W-1:0] diff;
    logic [OFF_W-1:0]        divisor;
    logic [OFF_W-1:0]        half;
    logic [NUM_W-1:0]        num;

    logic [OFF_W-1:0]        off_reg;
    logic [NUM_W-1:0]        rem_reg [0:STEPS-1];
    logic [BW-1:0]           q_reg   [1:STEPS];

    // Range and divisor follow the configuration, which the user must hold still
    // while words are in flight; the block itself does not enforce it.
    always_comb
    begin
        if (precision == '0)
            prec_eff = PW'(1);
        else if (precision > PREC_MAX)
            prec_eff = PREC_MAX;
        else
            prec_eff = precision;

        pow_p     = CMP_W'(1) << prec_eff;
        pow_h     = CMP_W'(1) << (prec_eff - PW'(1));
        span_full = pow_p - CMP_W'(1);
        half_full = pow_h - CMP_W'(1);

        if (sign_mode)
        begin
            hi = $signed(half_full);
            lo = $signed(-pow_h);
        end
        else
        begin
            hi = $signed(span_full);
            lo = '0;
        end

        s_ext = $signed({sample[cs2rgba_pkg::SAMPLE_W-1], sample});
        if (s_ext < lo)
            s_cl = lo;
        else if (s_ext > hi)
            s_cl = hi;
        else
            s_cl = s_ext;
        diff = s_cl - lo;
    end

    assign divisor = span_full[OFF_W-1:0];
    assign half    = half_full[OFF_W-1:0];

    always_ff @(posedge clk)
    begin
        if (en[0])
            off_reg <= diff[OFF_W-1:0];
    end

    // off * 255 + span / 2
    assign num = {off_reg, {BW{1'b0}}} - {{BW{1'b0}}, off_reg} + {{BW{1'b0}}, half};

    always_ff @(posedge clk)
    begin
        if (en[1])
            rem_reg[0] <= num;
    end

    for (genvar j = 0; j < STEPS; j++)
    begin : g_div
        logic [NUM_W-1:0] dsh;
        logic [BW-1:0]    q_in;
        logic             take;

        assign dsh  = {{BW{1'b0}}, divisor} << (STEPS - 1 - j);
        assign take = (rem_reg[j] >= dsh);

        if (j == 0)
        begin : g_first
            assign q_in = '0;
        end
        else
        begin : g_next
            assign q_in = q_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (en[BASE + j])
                q_reg[j+1] <= {q_in[BW-2:0], take};
        end

        if (j < STEPS - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en[BASE + j])
                    rem_reg[j+1] <= take ? (rem_reg[j] - dsh) : rem_reg[j];
            end
        end
    end

    assign value = q_reg[STEPS];

endmodule

// ----- rtl/cs2rgba_merge.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cs2rgba_merge
// Combines the four lane bytes into one RGBA pixel: gray fan-out, RGB pass
// or YCbCr to RGB conversion, and alpha selection. Two register stages.
// ----------------------------------------------------------------------------
module cs2rgba_merge (
    input  logic                                 clk,
    input  logic [cs2rgba_pkg::MERGE_STAGES-1:0] en,
    input  cs2rgba_pkg::pix_mode_t               mode,
    input  cs2rgba_pkg::byte_t                   lane_y,
    input  cs2rgba_pkg::byte_t                   lane_b,
    input  cs2rgba_pkg::byte_t                   lane_r,
    input  cs2rgba_pkg::byte_t                   lane_a,
    output cs2rgba_pkg::byte_t                   red,
    output cs2rgba_pkg::byte_t                   green,
    output cs2rgba_pkg::byte_t                   blue,
    output cs2rgba_pkg::byte_t                   alpha
);

    localparam int BW   = cs2rgba_pkg::BYTE_W;
    localparam int CW   = BW + 1;
    localparam int SW   = 27;
    localparam int FRAC = 16;

    function automatic cs2rgba_pkg::byte_t round_clamp(input logic signed [SW-1:0] v);
        logic [SW-1:0] t;
        begin
            t = ($unsigned(v) + SW'(32768)) >> FRAC;
            if (v[SW-1])
                round_clamp = '0;
            else if (t > SW'(cs2rgba_pkg::BYTE_MAX))
                round_clamp = cs2rgba_pkg::BYTE_MAX;
            else
                round_clamp = t[BW-1:0];
        end
    endfunction

    logic signed [CW-1:0] cb;
    logic signed [CW-1:0] cr;
    logic signed [SW-1:0] pr;
    logic signed [SW-1:0] pgb;
    logic signed [SW-1:0] pgr;
    logic signed [SW-1:0] pb;
    logic signed [SW-1:0] yterm;
    logic signed [SW-1:0] sr;
    logic signed [SW-1:0] sg;
    logic signed [SW-1:0] sb;

    cs2rgba_pkg::byte_t   y_reg;
    cs2rgba_pkg::byte_t   b_reg;
    cs2rgba_pkg::byte_t   r_reg;
    cs2rgba_pkg::byte_t   a_reg;
    logic signed [SW-1:0] pr_reg;
    logic signed [SW-1:0] pgb_reg;
    logic signed [SW-1:0] pgr_reg;
    logic signed [SW-1:0] pb_reg;

    cs2rgba_pkg::byte_t   red_reg;
    cs2rgba_pkg::byte_t   green_reg;
    cs2rgba_pkg::byte_t   blue_reg;
    cs2rgba_pkg::byte_t   alpha_reg;
    cs2rgba_pkg::byte_t   red_next;
    cs2rgba_pkg::byte_t   green_next;
    cs2rgba_pkg::byte_t   blue_next;
    cs2rgba_pkg::byte_t   alpha_next;

    assign cb  = $signed({1'b0, lane_b} - {1'b0, cs2rgba_pkg::CHROMA_BIAS});
    assign cr  = $signed({1'b0, lane_r} - {1'b0, cs2rgba_pkg::CHROMA_BIAS});
    assign pr  = $signed({1'b0, cs2rgba_pkg::COEF_KR})  * cr;
    assign pgb = $signed({1'b0, cs2rgba_pkg::COEF_KGB}) * cb;
    assign pgr = $signed({1'b0, cs2rgba_pkg::COEF_KGR}) * cr;
    assign pb  = $signed({1'b0, cs2rgba_pkg::COEF_KB})  * cb;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            y_reg   <= lane_y;
            b_reg   <= lane_b;
            r_reg   <= lane_r;
            a_reg   <= lane_a;
            pr_reg  <= pr;
            pgb_reg <= pgb;
            pgr_reg <= pgr;
            pb_reg  <= pb;
        end
    end

    assign yterm = $signed({{(SW-BW-FRAC){1'b0}}, y_reg, {FRAC{1'b0}}});
    assign sr    = yterm + pr_reg;
    assign sg    = yterm - pgb_reg - pgr_reg;
    assign sb    = yterm + pb_reg;

    always_comb
    begin
        if (mode.channel_mode == cs2rgba_pkg::CH_GRAY)
        begin
            red_next   = y_reg;
            green_next = y_reg;
            blue_next  = y_reg;
            alpha_next = cs2rgba_pkg::BYTE_MAX;
        end
        else
        begin
            if (mode.color_mode == cs2rgba_pkg::COLOR_YCC)
            begin
                red_next   = round_clamp(sr);
                green_next = round_clamp(sg);
                blue_next  = round_clamp(sb);
            end
            else
            begin
                red_next   = y_reg;
                green_next = b_reg;
                blue_next  = r_reg;
            end
            alpha_next = (mode.channel_mode >= cs2rgba_pkg::CH_FOUR) ? a_reg
                                                                    : cs2rgba_pkg::BYTE_MAX;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            alpha_reg <= alpha_next;
        end
    end

    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;
    assign alpha = alpha_reg;

endmodule

// ----- rtl/component_samples_to_rgba_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// component_samples_to_rgba_core
// Converts one pixel of up to four component samples into an RGBA word.
// ----------------------------------------------------------------------------
// Takes one pixel word per clock while the output side is not stalled and
// returns one RGBA word per pixel, in order. Each word passes through the
// per-component lanes: a clamp stage, a numerator stage and an eight-stage
// restoring divider that produces one bit of the rescaled byte per stage; two
// more stages hold the color products and the rounded, selected output. Each
// pipeline stage advances independently, so input words keep entering while a
// finished word waits at the output until the pipeline is full. Configuration
// must be written through the cfg port only while no pixel is in flight; the
// block itself does not enforce this.
module component_samples_to_rgba_core #(
    parameter int MAX_PRECISION = 31
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // sample_first [31:0], sample_second [63:32], sample_third [95:64],
    // sample_alpha [127:96]
    input  logic [127:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // red [7:0], green [15:8], blue [23:16], alpha [31:24]
    output logic [31:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [19:0]  cfg_data
);

    localparam int LANES  = cs2rgba_pkg::LANE_COUNT;
    localparam int STAGES = cs2rgba_pkg::PIPE_STAGES;
    localparam int LSTG   = cs2rgba_pkg::LANE_STAGES;
    localparam int SW     = cs2rgba_pkg::SAMPLE_W;
    localparam int PW     = cs2rgba_pkg::PREC_W;

    logic [1:0]          channel_mode_reg;
    logic                color_mode_reg;
    logic [LANES*PW-1:0] precisions_reg;
    logic [LANES-1:0]    signed_flags_reg;

    logic [STAGES-1:0]   valid_reg;
    logic [STAGES-1:0]   load;

    cs2rgba_pkg::byte_t  lane_byte [0:LANES-1];
    cs2rgba_pkg::pix_mode_t mode;
    cs2rgba_pkg::byte_t  red;
    cs2rgba_pkg::byte_t  green;
    cs2rgba_pkg::byte_t  blue;
    cs2rgba_pkg::byte_t  alpha;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_mode_reg <= cs2rgba_pkg::RST_CHANNEL_MODE;
            color_mode_reg   <= cs2rgba_pkg::RST_COLOR_MODE;
            precisions_reg   <= cs2rgba_pkg::RST_PRECISIONS;
            signed_flags_reg <= cs2rgba_pkg::RST_SIGNED_FLAGS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                cs2rgba_pkg::REG_CHANNEL_MODE: channel_mode_reg <= cfg_data[1:0];
                cs2rgba_pkg::REG_COLOR_MODE:   color_mode_reg   <= cfg_data[0];
                cs2rgba_pkg::REG_PRECISIONS:   precisions_reg   <= cfg_data[LANES*PW-1:0];
                cs2rgba_pkg::REG_SIGNED_FLAGS: signed_flags_reg <= cfg_data[LANES-1:0];
                default: ;
            endcase
        end
    end

    // A stage loads when it is empty or its content moves on.
    always_comb
    begin
        load[STAGES-1] = !valid_reg[STAGES-1] || m_tready;
        for (int i = STAGES - 2; i >= 0; i--)
            load[i] = !valid_reg[i] || load[i+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            if (load[0])
                valid_reg[0] <= s_tvalid;
            for (int i = 1; i < STAGES; i++)
                if (load[i])
                    valid_reg[i] <= valid_reg[i-1];
        end
    end

    assign s_tready = load[0];
    assign m_tvalid = valid_reg[STAGES-1];

    for (genvar k = 0; k < LANES; k++)
    begin : g_lane
        cs2rgba_lane #(
            .MAX_PRECISION (MAX_PRECISION)
        ) u_lane (
            .clk       (clk),
            .en        (load[LSTG-1:0]),
            .sample    (s_tdata[SW*k +: SW]),
            .precision (precisions_reg[PW*k +: PW]),
            .sign_mode (signed_flags_reg[k]),
            .value     (lane_byte[k])
        );
    end

    assign mode.channel_mode = channel_mode_reg;
    assign mode.color_mode   = color_mode_reg;

    cs2rgba_merge u_merge (
        .clk    (clk),
        .en     (load[STAGES-1:LSTG]),
        .mode   (mode),
        .lane_y (lane_byte[0]),
        .lane_b (lane_byte[1]),
        .lane_r (lane_byte[2]),
        .lane_a (lane_byte[3]),
        .red    (red),
        .green  (green),
        .blue   (blue),
        .alpha  (alpha)
    );

    assign m_tdata = {alpha, blue, green, red};

    // checks
    a_gray_fanout: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (channel_mode_reg == cs2rgba_pkg::CH_GRAY) |->
            (m_tdata[7:0] == m_tdata[15:8]) && (m_tdata[7:0] == m_tdata[23:16]) &&
            (m_tdata[31:24] == cs2rgba_pkg::BYTE_MAX))
        else $error("gray word lost fan-out or opaque alpha");

    a_three_opaque: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (channel_mode_reg == cs2rgba_pkg::CH_THREE) |->
            (m_tdata[31:24] == cs2rgba_pkg::BYTE_MAX))
        else $error("three-component word carries non-opaque alpha");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg[0] |-> s_tready)
        else $error("input held off with first stage empty");

    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> valid_reg[0])
        else $error("accepted word did not enter the pipeline");

endmodule

// ----- verif/tb_component_samples_to_rgba_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_component_samples_to_rgba_core
// Self-checking bench for the component sample to RGBA converter. A queue of
// pixel words feeds a stream driver; every accepted word is turned into an
// expected RGBA word by a local model of the clamp, byte rescale and YCbCr
// conversion. The monitor checks each output word field by field, in order.
// Register settings change between phases while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb_component_samples_to_rgba_core;

    localparam int         MAX_PREC    = 31;
    localparam int         CYCLE_LIMIT = 100000;
    localparam logic [1:0] CH_SPARE    = 2'd3;

    typedef struct packed {
        cs2rgba_pkg::byte_t alpha;
        cs2rgba_pkg::byte_t blue;
        cs2rgba_pkg::byte_t green;
        cs2rgba_pkg::byte_t red;
    } rgba_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [31:0]  m_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [1:0]   cfg_index = '0;
    logic [19:0]  cfg_data = '0;

    // local copy of the register file
    logic [1:0]  chan_cfg  = cs2rgba_pkg::RST_CHANNEL_MODE;
    logic        color_cfg = cs2rgba_pkg::RST_COLOR_MODE;
    logic [19:0] prec_cfg  = cs2rgba_pkg::RST_PRECISIONS;
    logic [3:0]  sflag_cfg = cs2rgba_pkg::RST_SIGNED_FLAGS;

    logic [127:0] pending_pixels[$];
    rgba_t        rgba_due[$];

    logic s_fire = 1'b0;
    logic cfg_fire = 1'b0;
    logic gaps_on = 1'b1;
    int   pixels_queued = 0;
    int   pixels_taken = 0;
    int   words_seen = 0;
    int   errors = 0;
    int   cycles = 0;
    int   settings_used = 0;

    component_samples_to_rgba_core #(
        .MAX_PRECISION(MAX_PREC)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic int unsigned lane_precision(int comp);
        int unsigned p;
        p = prec_cfg[comp*cs2rgba_pkg::PREC_W +: cs2rgba_pkg::PREC_W];
        if (p == 0)
            p = 1;
        if (p > MAX_PREC)
            p = MAX_PREC;
        return p;
    endfunction

    // clamp to the lane range, then rescale to a byte with rounding
    function automatic cs2rgba_pkg::byte_t lane_to_byte(int comp, logic [31:0] raw);
        int unsigned    p;
        longint         lo;
        longint         hi;
        longint         s;
        longint unsigned span;
        longint unsigned off;
        p = lane_precision(comp);
        if (sflag_cfg[comp])
        begin
            lo = -(longint'(1) << (p - 1));
            hi = (longint'(1) << (p - 1)) - 1;
        end
        else
        begin
            lo = 0;
            hi = (longint'(1) << p) - 1;
        end
        s = $signed(raw);
        if (s < lo)
            s = lo;
        if (s > hi)
            s = hi;
        span = hi - lo;
        off  = s - lo;
        return cs2rgba_pkg::byte_t'((off * 255 + span / 2) / span);
    endfunction

    // Q16 sum to byte: round half away from zero, clamp to 0..255
    function automatic cs2rgba_pkg::byte_t ycc_round(longint q);
        longint r;
        if (q >= 0)
            r = (q + 32768) >>> 16;
        else
            r = -((-q + 32768) >>> 16);
        if (r < 0)
            r = 0;
        if (r > 255)
            r = 255;
        return cs2rgba_pkg::byte_t'(r);
    endfunction

    function automatic rgba_t predict_rgba(logic [127:0] w);
        rgba_t  px;
        cs2rgba_pkg::byte_t b0;
        cs2rgba_pkg::byte_t b1;
        cs2rgba_pkg::byte_t b2;
        longint y;
        longint cb;
        longint cr;
        longint kr;
        longint kgb;
        longint kgr;
        longint kb;
        b0 = lane_to_byte(0, w[31:0]);
        if (chan_cfg == cs2rgba_pkg::CH_GRAY)
        begin
            px.red   = b0;
            px.green = b0;
            px.blue  = b0;
            px.alpha = cs2rgba_pkg::BYTE_MAX;
            return px;
        end
        b1 = lane_to_byte(1, w[63:32]);
        b2 = lane_to_byte(2, w[95:64]);
        if (color_cfg == cs2rgba_pkg::COLOR_YCC)
        begin
            kr  = cs2rgba_pkg::COEF_KR;
            kgb = cs2rgba_pkg::COEF_KGB;
            kgr = cs2rgba_pkg::COEF_KGR;
            kb  = cs2rgba_pkg::COEF_KB;
            y   = longint'(b0) * 65536;
            cb  = longint'(b1) - longint'(cs2rgba_pkg::CHROMA_BIAS);
            cr  = longint'(b2) - longint'(cs2rgba_pkg::CHROMA_BIAS);
            px.red   = ycc_round(y + kr * cr);
            px.green = ycc_round(y - kgb * cb - kgr * cr);
            px.blue  = ycc_round(y + kb * cb);
        end
        else
        begin
            px.red   = b0;
            px.green = b1;
            px.blue  = b2;
        end
        // the spare channel code behaves as four components
        px.alpha = (chan_cfg == cs2rgba_pkg::CH_THREE) ? cs2rgba_pkg::BYTE_MAX
                                                       : lane_to_byte(3, w[127:96]);
        return px;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        errors++;
        $display("[%0t] word %0d %s: got %0d, expected %0d",
                 $time, words_seen, what, got, want);
    endtask

    // sender: advance to the next word once the current one is taken
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || s_fire))
        begin
            if (pending_pixels.size() != 0 && !(gaps_on && $urandom_range(0, 99) < 31))
            begin
                s_tdata  <= pending_pixels.pop_front();
                s_tvalid <= 1'b1;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver back-pressure
    always @(negedge clk)
    begin
        m_tready <= gaps_on ? ($urandom_range(0, 99) >= 31) : 1'b1;
    end

    // sample handshakes, predict and check
    always @(posedge clk)
    begin
        rgba_t want;
        rgba_t got;
        cycles++;
        s_fire   <= rst_n && s_tvalid && s_tready;
        cfg_fire <= rst_n && cfg_valid && cfg_ready;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    cs2rgba_pkg::REG_CHANNEL_MODE: chan_cfg  = cfg_data[1:0];
                    cs2rgba_pkg::REG_COLOR_MODE:   color_cfg = cfg_data[0];
                    cs2rgba_pkg::REG_PRECISIONS:   prec_cfg  = cfg_data;
                    cs2rgba_pkg::REG_SIGNED_FLAGS: sflag_cfg = cfg_data[3:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                rgba_due.push_back(predict_rgba(s_tdata));
                pixels_taken++;
            end
            if (m_tvalid && m_tready)
            begin
                words_seen++;
                got = m_tdata;
                if (rgba_due.size() == 0)
                begin
                    report_mismatch("arrived with nothing pending", got, 0);
                end
                else
                begin
                    want = rgba_due.pop_front();
                    if (got.red !== want.red)
                        report_mismatch("red", got.red, want.red);
                    if (got.green !== want.green)
                        report_mismatch("green", got.green, want.green);
                    if (got.blue !== want.blue)
                        report_mismatch("blue", got.blue, want.blue);
                    if (got.alpha !== want.alpha)
                        report_mismatch("alpha", got.alpha, want.alpha);
                end
            end
        end
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d words still pending",
                     cycles, rgba_due.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [19:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(negedge clk);
        while (!cfg_fire);
        cfg_valid <= 1'b0;
    endtask

    // unused upper data bits carry noise half the time
    task automatic set_mode(input logic [1:0] ch, input logic color,
                            input logic [19:0] precs, input logic [3:0] flags);
        logic [19:0] pad;
        pad = $urandom_range(0, 1) ? 20'($urandom()) : 20'd0;
        write_reg(cs2rgba_pkg::REG_CHANNEL_MODE, {pad[19:2], ch});
        write_reg(cs2rgba_pkg::REG_COLOR_MODE, {pad[19:1], color});
        write_reg(cs2rgba_pkg::REG_PRECISIONS, precs);
        write_reg(cs2rgba_pkg::REG_SIGNED_FLAGS, {pad[19:4], flags});
        settings_used++;
    endtask

    task automatic random_setting();
        logic [19:0] precs;
        for (int i = 0; i < cs2rgba_pkg::LANE_COUNT; i++)
        begin
            case ($urandom_range(0, 5))
                0:       precs[i*cs2rgba_pkg::PREC_W +: cs2rgba_pkg::PREC_W] = 5'd0;
                1:       precs[i*cs2rgba_pkg::PREC_W +: cs2rgba_pkg::PREC_W] = 5'd1;
                2:       precs[i*cs2rgba_pkg::PREC_W +: cs2rgba_pkg::PREC_W] = 5'd31;
                3:       precs[i*cs2rgba_pkg::PREC_W +: cs2rgba_pkg::PREC_W] = 5'd8;
                default: precs[i*cs2rgba_pkg::PREC_W +: cs2rgba_pkg::PREC_W] =
                             5'($urandom_range(0, 31));
            endcase
        end
        set_mode(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), precs,
                 4'($urandom_range(0, 15)));
    endtask

    task automatic queue_pixel(input logic [31:0] s0, input logic [31:0] s1,
                               input logic [31:0] s2, input logic [31:0] s3);
        pending_pixels.push_back({s3, s2, s1, s0});
        pixels_queued++;
    endtask

    // mostly in range for the lane, with edges, overflows and raw noise
    function automatic logic [31:0] rand_sample(int comp);
        int unsigned p;
        logic [31:0] mask;
        logic [31:0] lo;
        logic [31:0] hi;
        p    = lane_precision(comp);
        mask = (32'h1 << p) - 1;
        if (sflag_cfg[comp])
        begin
            hi = mask >> 1;
            lo = ~hi;
        end
        else
        begin
            hi = mask;
            lo = '0;
        end
        case ($urandom_range(0, 9))
            0:       return $urandom();
            1:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            2:       return $urandom_range(0, 1) ? hi : lo;
            3:       return $urandom_range(0, 1) ? hi + 1 : lo - 1;
            default: return sflag_cfg[comp] ? ($urandom() & mask) - hi - 1 : $urandom() & mask;
        endcase
    endfunction

    task automatic queue_random(input int n);
        repeat (n)
            queue_pixel(rand_sample(0), rand_sample(1), rand_sample(2), rand_sample(3));
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pixels_taken != pixels_queued || rgba_due.size() != 0);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: three unsigned 8-bit components, RGB
        queue_pixel(32'd0, 32'd0, 32'd0, 32'd0);
        queue_pixel(32'd255, 32'd255, 32'd255, 32'd255);
        queue_pixel(32'hFFFF_FFFF, 32'h8000_0000, 32'd256, 32'h7FFF_FFFF);
        queue_pixel(32'd128, 32'd64, 32'd200, 32'd1);
        queue_random(40);
        wait_idle();

        // gray ignores color mode; precision zero acts as one bit
        set_mode(cs2rgba_pkg::CH_GRAY, cs2rgba_pkg::COLOR_YCC, 20'd0, 4'h0);
        queue_pixel(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_pixel(32'd1, 32'd0, 32'd0, 32'd0);
        queue_pixel(32'hFFFF_FFFF, 32'd1, 32'd1, 32'd1);
        queue_pixel(32'd2, 32'd0, 32'd0, 32'd0);
        queue_random(40);
        wait_idle();

        // YCbCr corners drive every output into both clamps
        set_mode(cs2rgba_pkg::CH_THREE, cs2rgba_pkg::COLOR_YCC,
                 cs2rgba_pkg::RST_PRECISIONS, 4'h0);
        queue_pixel(32'd0, 32'd128, 32'd128, 32'd0);
        queue_pixel(32'd255, 32'd128, 32'd128, 32'd0);
        queue_pixel(32'd255, 32'd0, 32'd255, 32'd0);
        queue_pixel(32'd0, 32'd255, 32'd255, 32'd0);
        queue_pixel(32'd128, 32'd0, 32'd0, 32'd0);
        queue_pixel(32'd255, 32'd255, 32'd0, 32'd0);
        queue_random(80);
        wait_idle();

        // widest signed lanes with alpha
        set_mode(cs2rgba_pkg::CH_FOUR, cs2rgba_pkg::COLOR_YCC, 20'hFFFFF, 4'hF);
        queue_pixel(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        queue_pixel(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        queue_pixel(32'd0, 32'd0, 32'd0, 32'd0);
        queue_random(60);
        wait_idle();

        // spare channel code, mixed precisions and signedness
        set_mode(CH_SPARE, cs2rgba_pkg::COLOR_RGB, {5'd16, 5'd1, 5'd12, 5'd3}, 4'b1010);
        queue_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_pixel(32'd7, 32'd1, 32'h0000_0800, 32'hFFFF_8000);
        queue_random(60);
        wait_idle();

        // full rate on both sides
        gaps_on = 1'b0;
        random_setting();
        queue_random(100);
        wait_idle();
        gaps_on = 1'b1;

        repeat (4)
        begin
            random_setting();
            queue_random(40);
            wait_idle();
        end

        repeat (cs2rgba_pkg::PIPE_STAGES + 8) @(negedge clk);
        if (rgba_due.size() != 0)
            report_mismatch("words never arrived", 0, rgba_due.size());

        $display("Checked %0d RGBA words from %0d pixels across %0d register settings",
                 words_seen, pixels_taken, settings_used + 1);
        $display("Covered gray, three, four and spare channel codes, RGB and YCbCr, clamping");
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
